### rtl/core/mini_c_tokenizer_core_macros.svh
// Assertion macros used by the tokenizer RTL.
`ifndef MINI_C_TOKENIZER_CORE_MACROS_SVH
`define MINI_C_TOKENIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mct_pkg.sv
// Package with types, token codes and decode functions of the tokenizer.
`timescale 1ns / 1ps

package mct_pkg;

    localparam int MAX_TEXT_LEN = 64;
    localparam int LINE_BITS    = 16;
    localparam int LEN_W        = $clog2(MAX_TEXT_LEN + 1);
    localparam int PREFIX_BYTES = 6;
    localparam int MAX_RESULTS  = 3;
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 64;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NAME   = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_OPER   = 2'd3
    } t_mode;

    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_GT   = 4'd1;
    localparam logic [3:0] OP_LT   = 4'd2;
    localparam logic [3:0] OP_EQ   = 4'd3;
    localparam logic [3:0] OP_NOT  = 4'd4;
    localparam logic [3:0] OP_AMP  = 4'd5;
    localparam logic [3:0] OP_BAR  = 4'd6;
    localparam logic [3:0] OP_ADD  = 4'd7;
    localparam logic [3:0] OP_SUB  = 4'd8;
    localparam logic [3:0] OP_MUL  = 4'd9;
    localparam logic [3:0] OP_DIV  = 4'd10;

    localparam logic [5:0] K_ID          = 6'd0;
    localparam logic [5:0] K_NUM         = 6'd1;
    localparam logic [5:0] K_INT         = 6'd3;
    localparam logic [5:0] K_FLOAT_TYPE  = 6'd4;
    localparam logic [5:0] K_VOID        = 6'd5;
    localparam logic [5:0] K_IF          = 6'd6;
    localparam logic [5:0] K_ELSE        = 6'd7;
    localparam logic [5:0] K_WHILE       = 6'd8;
    localparam logic [5:0] K_RETURN      = 6'd9;
    localparam logic [5:0] K_PLUS        = 6'd12;
    localparam logic [5:0] K_MINUS       = 6'd13;
    localparam logic [5:0] K_MUL         = 6'd14;
    localparam logic [5:0] K_DIV         = 6'd15;
    localparam logic [5:0] K_ASSIGN      = 6'd16;
    localparam logic [5:0] K_PLUS_ASSIGN = 6'd17;
    localparam logic [5:0] K_INC         = 6'd18;
    localparam logic [5:0] K_LT          = 6'd19;
    localparam logic [5:0] K_LE          = 6'd20;
    localparam logic [5:0] K_EQ          = 6'd21;
    localparam logic [5:0] K_GT          = 6'd22;
    localparam logic [5:0] K_GE          = 6'd23;
    localparam logic [5:0] K_NE          = 6'd24;
    localparam logic [5:0] K_AND         = 6'd25;
    localparam logic [5:0] K_OR          = 6'd26;
    localparam logic [5:0] K_NOT         = 6'd27;
    localparam logic [5:0] K_LPAREN      = 6'd28;
    localparam logic [5:0] K_RPAREN      = 6'd29;
    localparam logic [5:0] K_LBRACE      = 6'd32;
    localparam logic [5:0] K_RBRACE      = 6'd33;
    localparam logic [5:0] K_COMMA       = 6'd34;
    localparam logic [5:0] K_SEMICOLON   = 6'd35;
    localparam logic [5:0] K_EOF         = 6'd36;
    localparam logic [5:0] K_ERROR       = 6'd37;
    localparam logic [5:0] K_NONE        = 6'd63;

    typedef struct packed {
        logic [5:0]  kind;
        logic [30:0] value;
        logic [15:0] line;
        logic [6:0]  len;
        logic        last;
    } t_result;

    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [1:0]                count;
    } t_bundle;

    function automatic logic is_space(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B
            || c == 8'h0C || c == 8'h0D;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [3:0] op_code(logic [7:0] c);
        logic [3:0] r;
        unique case (c)
            ">":     r = OP_GT;
            "<":     r = OP_LT;
            "=":     r = OP_EQ;
            "!":     r = OP_NOT;
            "&":     r = OP_AMP;
            "|":     r = OP_BAR;
            "+":     r = OP_ADD;
            "-":     r = OP_SUB;
            "*":     r = OP_MUL;
            "/":     r = OP_DIV;
            default: r = OP_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] op_single(logic [3:0] p);
        logic [5:0] r;
        unique case (p)
            OP_GT:   r = K_GT;
            OP_LT:   r = K_LT;
            OP_EQ:   r = K_ASSIGN;
            OP_NOT:  r = K_NOT;
            OP_ADD:  r = K_PLUS;
            OP_SUB:  r = K_MINUS;
            OP_MUL:  r = K_MUL;
            OP_DIV:  r = K_DIV;
            default: r = K_ERROR;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] pair_kind(logic [3:0] p, logic [7:0] c);
        logic [5:0] r;
        logic       eq;
        eq = (c == "=");
        unique case (p)
            OP_GT:   r = eq ? K_GE : K_NONE;
            OP_LT:   r = eq ? K_LE : K_NONE;
            OP_EQ:   r = eq ? K_EQ : K_NONE;
            OP_NOT:  r = eq ? K_NE : K_NONE;
            OP_AMP:  r = (c == "&") ? K_AND : K_NONE;
            OP_BAR:  r = (c == "|") ? K_OR : K_NONE;
            OP_ADD:  r = (c == "+") ? K_INC : (eq ? K_PLUS_ASSIGN : K_NONE);
            OP_SUB:  r = (c == "-") ? K_INC : (eq ? K_PLUS_ASSIGN : K_NONE);
            OP_MUL:  r = eq ? K_PLUS_ASSIGN : K_NONE;
            OP_DIV:  r = eq ? K_PLUS_ASSIGN : K_NONE;
            default: r = K_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] delim_kind(logic [7:0] c);
        logic [5:0] r;
        unique case (c)
            "(":     r = K_LPAREN;
            ")":     r = K_RPAREN;
            "{":     r = K_LBRACE;
            "}":     r = K_RBRACE;
            ",":     r = K_COMMA;
            ";":     r = K_SEMICOLON;
            default: r = K_ERROR;
        endcase
        return r;
    endfunction

    // The prefix holds up to six bytes, the first byte highest.
    function automatic logic [5:0] name_kind(logic [47:0] p, logic [LEN_W-1:0] n);
        logic [5:0] r;
        r = K_ID;
        if (n == LEN_W'(3) && p == 48'h0000_0069_6E74) begin
            r = K_INT;
        end else if (n == LEN_W'(5) && p == 48'h0066_6C6F_6174) begin
            r = K_FLOAT_TYPE;
        end else if (n == LEN_W'(4) && p == 48'h0000_766F_6964) begin
            r = K_VOID;
        end else if (n == LEN_W'(2) && p == 48'h0000_0000_6966) begin
            r = K_IF;
        end else if (n == LEN_W'(4) && p == 48'h0000_656C_7365) begin
            r = K_ELSE;
        end else if (n == LEN_W'(5) && p == 48'h0077_6869_6C65) begin
            r = K_WHILE;
        end else if (n == LEN_W'(6) && p == 48'h7265_7475_726E) begin
            r = K_RETURN;
        end
        return r;
    endfunction

endpackage

### rtl/core/mct_scan.sv
// Scanner state and per-byte token decision for the tokenizer.
`timescale 1ns / 1ps

module mct_scan (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [7:0]                          i_ch,
    input  logic                                i_end_of_text,
    output mct_pkg::t_bundle                    o_bundle
);

    mct_pkg::t_mode                     r_mode, n_mode;
    logic [3:0]                         r_pend, n_pend;
    logic [47:0]                        r_prefix, n_prefix;
    logic [mct_pkg::LEN_W-1:0]          r_len, n_len;
    logic [30:0]                        r_acc, n_acc;
    logic [mct_pkg::LINE_BITS-1:0]      r_cur_line, n_cur_line;
    logic [mct_pkg::LINE_BITS-1:0]      r_tok_line, n_tok_line;

    mct_pkg::t_result                   cand [4];
    logic [3:0]                         cand_v;
    logic [34:0]                        prod;
    logic [5:0]                         pk;
    logic [3:0]                         opc;

    function automatic mct_pkg::t_result close_result(
        mct_pkg::t_mode                 mode,
        logic [3:0]                     pend,
        logic [47:0]                    prefix,
        logic [mct_pkg::LEN_W-1:0]      len,
        logic [30:0]                    acc,
        logic [mct_pkg::LINE_BITS-1:0]  line
    );
        mct_pkg::t_result r;
        r       = '0;
        r.line  = 16'(line);
        r.len   = 7'(len);
        unique case (mode)
            mct_pkg::MODE_NAME: begin
                r.kind = mct_pkg::name_kind(prefix, len);
            end
            mct_pkg::MODE_NUMBER: begin
                r.kind  = mct_pkg::K_NUM;
                r.value = acc;
            end
            mct_pkg::MODE_OPER: begin
                r.kind = mct_pkg::op_single(pend);
                r.len  = 7'd1;
            end
            default: begin
                r.kind = mct_pkg::K_ERROR;
            end
        endcase
        return r;
    endfunction

    assign pk   = mct_pkg::pair_kind(r_pend, i_ch);
    assign opc  = mct_pkg::op_code(i_ch);
    assign prod = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 35'(i_ch - 8'h30);

    always_comb begin
        n_mode     = r_mode;
        n_pend     = r_pend;
        n_prefix   = r_prefix;
        n_len      = r_len;
        n_acc      = r_acc;
        n_cur_line = r_cur_line;
        n_tok_line = r_tok_line;
        cand_v     = '0;
        for (int j = 0; j < 4; j++) begin
            cand[j] = '0;
        end

        if (r_mode == mct_pkg::MODE_NAME
                && (mct_pkg::is_alpha(i_ch) || mct_pkg::is_digit(i_ch))) begin
            if (r_len < mct_pkg::LEN_W'(mct_pkg::PREFIX_BYTES)) begin
                n_prefix = {r_prefix[39:0], i_ch};
            end
            if (r_len < mct_pkg::LEN_W'(mct_pkg::MAX_TEXT_LEN)) begin
                n_len = r_len + 1'b1;
            end
        end else if (r_mode == mct_pkg::MODE_NUMBER && mct_pkg::is_digit(i_ch)) begin
            n_acc = (prod > {4'b0, mct_pkg::NUM_MAX}) ? mct_pkg::NUM_MAX : prod[30:0];
            if (r_len < mct_pkg::LEN_W'(mct_pkg::MAX_TEXT_LEN)) begin
                n_len = r_len + 1'b1;
            end
        end else if (r_mode == mct_pkg::MODE_OPER && pk != mct_pkg::K_NONE) begin
            cand_v[0]    = 1'b1;
            cand[0].kind = pk;
            cand[0].line = 16'(r_tok_line);
            cand[0].len  = 7'd2;
            n_mode       = mct_pkg::MODE_IDLE;
            n_pend       = mct_pkg::OP_NONE;
        end else begin
            if (r_mode != mct_pkg::MODE_IDLE) begin
                cand_v[0] = 1'b1;
                cand[0]   = close_result(r_mode, r_pend, r_prefix, r_len, r_acc, r_tok_line);
            end
            n_mode   = mct_pkg::MODE_IDLE;
            n_pend   = mct_pkg::OP_NONE;
            n_prefix = '0;
            n_len    = '0;
            n_acc    = '0;
            if (mct_pkg::is_space(i_ch)) begin
                if (i_ch == 8'h0A && r_cur_line != '1) begin
                    n_cur_line = r_cur_line + 1'b1;
                end
            end else begin
                n_tok_line = r_cur_line;
                if (mct_pkg::is_alpha(i_ch)) begin
                    n_mode   = mct_pkg::MODE_NAME;
                    n_prefix = {40'b0, i_ch};
                    n_len    = mct_pkg::LEN_W'(1);
                end else if (mct_pkg::is_digit(i_ch)) begin
                    n_mode = mct_pkg::MODE_NUMBER;
                    n_acc  = 31'(i_ch - 8'h30);
                    n_len  = mct_pkg::LEN_W'(1);
                end else if (opc != mct_pkg::OP_NONE) begin
                    n_mode = mct_pkg::MODE_OPER;
                    n_pend = opc;
                end else begin
                    cand_v[1]    = 1'b1;
                    cand[1].kind = mct_pkg::delim_kind(i_ch);
                    cand[1].line = 16'(r_cur_line);
                    cand[1].len  = 7'd1;
                end
            end
        end

        if (i_end_of_text) begin
            if (n_mode != mct_pkg::MODE_IDLE) begin
                cand_v[2] = 1'b1;
                cand[2]   = close_result(n_mode, n_pend, n_prefix, n_len, n_acc, n_tok_line);
            end
            cand_v[3]    = 1'b1;
            cand[3].kind = mct_pkg::K_EOF;
            cand[3].line = 16'(n_cur_line);
            cand[3].len  = 7'd3;
            n_mode       = mct_pkg::MODE_IDLE;
            n_pend       = mct_pkg::OP_NONE;
            n_prefix     = '0;
            n_len        = '0;
            n_acc        = '0;
            n_cur_line   = mct_pkg::LINE_BITS'(1);
            n_tok_line   = mct_pkg::LINE_BITS'(1);
        end
    end

    always_comb begin
        o_bundle = '0;
        for (int j = 0; j < 4; j++) begin
            if (cand_v[j] && o_bundle.count != 2'd3) begin
                o_bundle.res[o_bundle.count] = cand[j];
                o_bundle.count               = o_bundle.count + 2'd1;
            end
        end
        if (o_bundle.count != 2'd0) begin
            o_bundle.res[o_bundle.count - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= mct_pkg::MODE_IDLE;
            r_pend     <= mct_pkg::OP_NONE;
            r_prefix   <= '0;
            r_len      <= '0;
            r_acc      <= '0;
            r_cur_line <= mct_pkg::LINE_BITS'(1);
            r_tok_line <= mct_pkg::LINE_BITS'(1);
        end else if (i_accept) begin
            r_mode     <= n_mode;
            r_pend     <= n_pend;
            r_prefix   <= n_prefix;
            r_len      <= n_len;
            r_acc      <= n_acc;
            r_cur_line <= n_cur_line;
            r_tok_line <= n_tok_line;
        end
    end

endmodule

### rtl/core/mct_out.sv
// Result register that holds the tokens of one byte and hands them out one per cycle while i_ready is high.
`timescale 1ns / 1ps
`include "mini_c_tokenizer_core_macros.svh"

module mct_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mct_pkg::t_bundle  i_bundle,
    input  logic              i_ready,
    output logic              o_valid,
    output mct_pkg::t_result  o_result,
    output logic              o_in_ready
);

    mct_pkg::t_result [mct_pkg::MAX_RESULTS-1:0] r_res;
    logic [1:0]                                  r_cnt;
    logic                                        take;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_result   = r_res[0];
    assign take       = o_valid && i_ready;
    assign o_in_ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_bundle.count;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_bundle.res;
        end else if (take) begin
            r_res <= {r_res[2], r_res[2:1]};
        end
    end

    `MCT_ASSERT_IMP(a_load_room, i_clk, i_rst_n, i_load, r_cnt == 2'd0 || (r_cnt == 2'd1 && i_ready), "Transaction loaded over pending tokens.")
    `MCT_ASSERT_NXT(a_load_shows, i_clk, i_rst_n, i_load && i_bundle.count != 2'd0, o_valid && r_cnt == $past(i_bundle.count), "Loaded tokens not presented.")
    `MCT_ASSERT_IMP(a_last_flag, i_clk, i_rst_n, o_valid, o_result.last == (r_cnt == 2'd1), "Last flag does not match the final token of a byte.")
    `MCT_ASSERT_IMP(a_kind_range, i_clk, i_rst_n, o_valid, o_result.kind <= mct_pkg::K_ERROR, "Token kind out of range.")

endmodule

### rtl/core/mini_c_tokenizer_core.sv
// Top level of the C subset tokenizer: byte stream in, token stream out.
// Output: the first token caused by a byte appears in the cycle after its transaction.
// Throughput: one byte per cycle while each byte yields at most one token and
// m_axis_tready is high; a byte that yields N tokens (N up to 3) holds the input
// while the result register drains them one per cycle, if m_axis_tready is high.
// Reset: synchronous, active low; line count returns to 1 and pending tokens are dropped.
`timescale 1ns / 1ps

module mini_c_tokenizer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mct_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [7:0] ch
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [5:0] token_kind, [36:6] number_value, [52:37] start_line,
    // [59:53] lexeme_length, [63:60] zero
    output logic [mct_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast
);

    logic              accept;
    mct_pkg::t_bundle  bundle;
    mct_pkg::t_result  result;

    assign accept = s_axis_tvalid && s_axis_tready;

    mct_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_ch          (s_axis_tdata),
        .i_end_of_text (s_axis_tlast),
        .o_bundle      (bundle)
    );

    mct_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_bundle   (bundle),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_result   (result),
        .o_in_ready (s_axis_tready)
    );

    assign m_axis_tdata = {4'b0, result.len, result.line, result.value, result.kind};
    assign m_axis_tlast = result.last;

endmodule
